/* rtl/assert_macros.svh */
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, off during reset
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

// next-cycle implication, always on
`define ASSERT_NEXT_ALL(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/pidtic_pkg.sv */
// types and constants of the pid block with trapezoid integral and clamp
// no dependencies
package pidtic_pkg;

  localparam int SAMPLE_W = 16;
  localparam int ERR_W    = 17;
  localparam int SUM_W    = 32;
  localparam int DRIVE_W  = 24;
  localparam int MUL_A_W  = 32;
  localparam int MUL_B_W  = 22;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int ACC_W    = 58;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;

  // 0.05 as 3277/65536
  localparam logic signed [MUL_B_W-1:0] TRAP_NUM = 22'sd3277;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P    = 3'd0,
    REG_GAIN_I    = 3'd1,
    REG_GAIN_D    = 3'd2,
    REG_OUT_UPPER = 3'd3,
    REG_OUT_LOWER = 3'd4
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INC,
    S_PGD,
    S_PE,
    S_IS,
    S_DV,
    S_ADD,
    S_FIN,
    S_OUT
  } state_t;

  typedef enum logic [2:0] {
    MUL_INC,
    MUL_PGD,
    MUL_PE,
    MUL_IS,
    MUL_DV
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_INC,
    ACC_PGD,
    ACC_LOAD8,
    ACC_ADD8,
    ACC_ADD
  } acc_op_t;

  typedef struct packed {
    logic     load_err;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     clamp;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] gain_p;
    logic signed [SAMPLE_W-1:0] gain_i;
    logic signed [SAMPLE_W-1:0] gain_d;
    logic signed [DRIVE_W-1:0]  out_upper;
    logic signed [DRIVE_W-1:0]  out_lower;
  } cfg_t;

endpackage

/* rtl/pidtic_cfg.sv */
// configuration registers: gains and output bounds
// depends on pidtic_pkg
module pidtic_cfg
  import pidtic_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_GAIN_P:    cfg_nxt.gain_p    = cfg_wdata[SAMPLE_W-1:0];
        REG_GAIN_I:    cfg_nxt.gain_i    = cfg_wdata[SAMPLE_W-1:0];
        REG_GAIN_D:    cfg_nxt.gain_d    = cfg_wdata[SAMPLE_W-1:0];
        REG_OUT_UPPER: cfg_nxt.out_upper = cfg_wdata[DRIVE_W-1:0];
        REG_OUT_LOWER: cfg_nxt.out_lower = cfg_wdata[DRIVE_W-1:0];
        default:       cfg_nxt = cfg_r;  // unmapped index ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p    <= 16'sd256;
      cfg_r.gain_i    <= '0;
      cfg_r.gain_d    <= '0;
      cfg_r.out_upper <= 24'sh7FFFFF;
      cfg_r.out_lower <= 24'sh800000;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/pidtic_ctrl.sv */
// sequencer: walks one sample through the shared multiplier and accumulator
// depends on pidtic_pkg
module pidtic_ctrl
  import pidtic_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  output logic out_tvalid,
  input  logic out_tready,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_tvalid) state_nxt = S_INC;
      S_INC:   state_nxt = S_PGD;
      S_PGD:   state_nxt = S_PE;
      S_PE:    state_nxt = S_IS;
      S_IS:    state_nxt = S_DV;
      S_DV:    state_nxt = S_ADD;
      S_ADD:   state_nxt = S_FIN;
      S_FIN:   state_nxt = S_OUT;
      S_OUT:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '{load_err: 1'b0, mul_sel: MUL_INC, acc_op: ACC_NONE,
                  clamp: 1'b0, load_out: 1'b0};
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready    = 1'b1;
        cmd.load_err = in_tvalid;
      end
      S_INC:   cmd.mul_sel = MUL_INC;
      S_PGD: begin
        cmd.mul_sel = MUL_PGD;
        cmd.acc_op  = ACC_INC;
      end
      S_PE: begin
        cmd.mul_sel = MUL_PE;
        cmd.acc_op  = ACC_PGD;
      end
      S_IS: begin
        cmd.mul_sel = MUL_IS;
        cmd.acc_op  = ACC_LOAD8;
      end
      S_DV: begin
        cmd.mul_sel = MUL_DV;
        cmd.acc_op  = ACC_ADD8;
      end
      S_ADD:   cmd.acc_op = ACC_ADD;
      S_FIN:   cmd.clamp = 1'b1;
      S_OUT:   cmd.load_out = out_free;
      default: cmd.load_out = 1'b0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_tready)       out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

/* rtl/pidtic_dp.sv */
// datapath: error, integral, derivative, one shared 32x22 multiplier,
// accumulator, rounding, clamp and output register; depends on pidtic_pkg
module pidtic_dp
  import pidtic_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  cmd_t                cmd,
  input  cfg_t                cfg,
  input  logic [SAMPLE_W-1:0] target,
  input  logic [SAMPLE_W-1:0] measured,
  output logic [DRIVE_W-1:0]  drive
);

  localparam int Y_W = ACC_W - 16;

  logic signed [ERR_W-1:0]   e_r, last_r, last_nxt;
  logic signed [SUM_W-1:0]   sum_r, sum_nxt;
  logic signed [MUL_B_W-1:0] deriv_r, deriv_nxt;
  logic signed [SUM_W-1:0]   pgd_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic signed [DRIVE_W-1:0] res_r, drive_r;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [ERR_W:0]     e_add, e_sub;
  logic signed [PROD_W-1:0]  inc_rnd;
  logic signed [13:0]        inc;
  logic signed [SUM_W:0]     sum_wide;
  logic signed [ACC_W-1:0]   prod_ext, acc_rnd;
  logic signed [Y_W-1:0]     y, up_ext, lo_ext;
  logic signed [ERR_W-1:0]   e_in;

  assign e_in  = {target[SAMPLE_W-1], target} - {measured[SAMPLE_W-1], measured};
  assign e_add = {e_r[ERR_W-1], e_r} + {last_r[ERR_W-1], last_r};
  assign e_sub = {e_r[ERR_W-1], e_r} - {last_r[ERR_W-1], last_r};

  // operand select for the shared multiplier
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_INC: begin
        mul_a = {{(MUL_A_W-ERR_W-1){e_add[ERR_W]}}, e_add};
        mul_b = TRAP_NUM;
      end
      MUL_PGD: begin
        mul_a = {{(MUL_A_W-SAMPLE_W){cfg.gain_p[SAMPLE_W-1]}}, cfg.gain_p};
        mul_b = {{(MUL_B_W-SAMPLE_W){cfg.gain_d[SAMPLE_W-1]}}, cfg.gain_d};
      end
      MUL_PE: begin
        mul_a = {{(MUL_A_W-SAMPLE_W){cfg.gain_p[SAMPLE_W-1]}}, cfg.gain_p};
        mul_b = {{(MUL_B_W-ERR_W){e_r[ERR_W-1]}}, e_r};
      end
      MUL_IS: begin
        mul_a = sum_r;
        mul_b = {{(MUL_B_W-SAMPLE_W){cfg.gain_i[SAMPLE_W-1]}}, cfg.gain_i};
      end
      MUL_DV: begin
        mul_a = pgd_r;
        mul_b = deriv_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // integral increment rounded half up, then saturating add
  assign inc_rnd  = prod_r + 54'sd32768;
  assign inc      = inc_rnd[29:16];
  assign sum_wide = {sum_r[SUM_W-1], sum_r} + {{(SUM_W-13){inc[13]}}, inc};
  assign prod_ext = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};

  always_comb begin
    sum_nxt   = sum_r;
    last_nxt  = last_r;
    deriv_nxt = deriv_r;
    acc_nxt   = acc_r;
    unique case (cmd.acc_op)
      ACC_INC: begin
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
          sum_nxt = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                    : {1'b0, {(SUM_W-1){1'b1}}};
        else
          sum_nxt = sum_wide[SUM_W-1:0];
        last_nxt  = e_r;
        // times ten as 8x + 2x
        deriv_nxt = ({{(MUL_B_W-ERR_W-1){e_sub[ERR_W]}}, e_sub} <<< 3)
                  + ({{(MUL_B_W-ERR_W-1){e_sub[ERR_W]}}, e_sub} <<< 1);
      end
      ACC_LOAD8: acc_nxt = prod_ext <<< 8;
      ACC_ADD8:  acc_nxt = acc_r + (prod_ext <<< 8);
      ACC_ADD:   acc_nxt = acc_r + prod_ext;
      ACC_NONE, ACC_PGD: acc_nxt = acc_r;
      default:   acc_nxt = acc_r;
    endcase
  end

  // round half up from Q.16 to Q.0 and clamp, upper bound tested first
  assign acc_rnd = acc_r + 58'sd32768;
  assign y       = acc_rnd[ACC_W-1:16];
  assign up_ext  = {{(Y_W-DRIVE_W){cfg.out_upper[DRIVE_W-1]}}, cfg.out_upper};
  assign lo_ext  = {{(Y_W-DRIVE_W){cfg.out_lower[DRIVE_W-1]}}, cfg.out_lower};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '0;
      sum_r  <= '0;
    end else begin
      last_r <= last_nxt;
      sum_r  <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r  <= mul_a * mul_b;
    deriv_r <= deriv_nxt;
    acc_r   <= acc_nxt;
    if (cmd.load_err) e_r <= e_in;
    if (cmd.acc_op == ACC_PGD) pgd_r <= prod_r[SUM_W-1:0];
    if (cmd.clamp) begin
      if (y > up_ext)      res_r <= cfg.out_upper;
      else if (y < lo_ext) res_r <= cfg.out_lower;
      else                 res_r <= y[DRIVE_W-1:0];
    end
    if (cmd.load_out) drive_r <= res_r;
  end

  assign drive = drive_r;

endmodule

/* rtl/pid_trapezoid_integral_clamp_top.sv */
// top level of the pid controller with trapezoid integral and output clamp
// depends on pidtic_pkg, pidtic_cfg, pidtic_ctrl, pidtic_dp
//
//   channel  | direction | payload (lsb first)          | handshake
//   in_      | slave     | target[15:0], measured[31:16] | tvalid/tready
//   out_     | master    | drive[23:0]                   | tvalid/tready
//   cfg_     | write     | index 0..4, data[23:0]        | wr_en, no wait
//
// out_tvalid rises once the sequencer has stepped an accepted sample through:
// five products through one shared 32x22 multiplier, then add, round and clamp;
// in_tready is high only while the sequencer is idle
// an unclaimed output beat holds; a new sample is still taken and waits at the end
// reset (rst_n low, synchronous) clears the integral, the last error, the gains
// to their defaults and drops out_tvalid
module pid_trapezoid_integral_clamp_top
  import pidtic_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [31:0]           in_tdata,   // target[15:0], measured[31:16]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [DRIVE_W-1:0]    out_tdata,  // drive[23:0]
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t cfg;
  cmd_t cmd;

  // gain and bound registers
  pidtic_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // sequencer owns both handshakes
  pidtic_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // arithmetic, state and output register
  pidtic_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .cfg      (cfg),
    .target   (in_tdata[SAMPLE_W-1:0]),
    .measured (in_tdata[2*SAMPLE_W-1:SAMPLE_W]),
    .drive    (out_tdata)
  );

endmodule

/* rtl/pidtic_checker.sv */
// port-level checks of the pid block, bound to the top level
// depends on assert_macros.svh and pid_trapezoid_integral_clamp_top
`include "assert_macros.svh"

module pidtic_checker (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready
);

  logic in_beat;

  assign in_beat = in_tvalid && in_tready;

  // a stalled output beat stays offered
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  // reset empties the output register
  `ASSERT_NEXT_ALL(a_rst_clear, clk, !rst_n, !out_tvalid)
  // one sample in flight: no beat taken right after another
  `ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_beat, !in_tready)
  // a result never appears the cycle after its sample is taken
  `ASSERT_IMPL(a_min_latency, clk, rst_n, $rose(out_tvalid),
               !$past(in_tvalid && in_tready))

endmodule

bind pid_trapezoid_integral_clamp_top pidtic_checker u_pidtic_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
